// ----- design/alu_branch_execute_unit_core_macros.svh -----
// assertion macros for the alu branch execute unit
`ifndef ALU_BRANCH_EXECUTE_UNIT_CORE_MACROS_SVH
`define ALU_BRANCH_EXECUTE_UNIT_CORE_MACROS_SVH
// implication checked on every clock, off during reset
`define ABE_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define ABE_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

// ----- design/abeu_pkg.sv -----
// shared types and constants of the alu branch execute unit
`default_nettype none
package abeu_pkg;
  localparam int unsigned DataW = 32;
  localparam int unsigned CsW = 16;
  localparam int unsigned OpW = 5;
  localparam int unsigned DivCntW = 6;

  typedef enum logic [4:0] {
    OP_SYS = 5'd0, OP_JMP = 5'd1, OP_JP = 5'd2, OP_JN = 5'd3, OP_JZ = 5'd4,
    OP_JC = 5'd5, OP_JV = 5'd6, OP_JNP = 5'd7, OP_JNN = 5'd8, OP_JNZ = 5'd9,
    OP_NOT = 5'd10, OP_STOP = 5'd11, OP_MOV = 5'd12, OP_ADD = 5'd13,
    OP_SUB = 5'd14, OP_MUL = 5'd15, OP_DIV = 5'd16, OP_CMP = 5'd17,
    OP_AND = 5'd18, OP_OR = 5'd19, OP_XOR = 5'd20, OP_SWAP = 5'd21,
    OP_SHL = 5'd22, OP_SHR = 5'd23, OP_SAR = 5'd24, OP_LDL = 5'd25,
    OP_LDH = 5'd26
  } op_t;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_DIV0 = 2'd1;
  localparam logic [1:0] ST_BADOP = 2'd2;
  localparam logic [1:0] ST_SYS = 2'd3;

  // controller to datapath
  typedef struct packed {
    logic load;      // capture the beat, start work
    logic div_step;  // one restoring division step
    logic finish;    // form the result register
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_div;    // divide with nonzero divisor
  } dp_sts_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [DataW-1:0] remainder;
    logic             remainder_valid;
    logic [DataW-1:0] jump_target;
    logic             jump_taken;
    logic [3:0]       flags_now;
    logic [DataW-1:0] value_b;
    logic             write_b;
    logic [DataW-1:0] value_a;
    logic             write_a;
  } res_t;

  function automatic logic [3:0] mkflags(input logic [DataW-1:0] r, input logic c,
                                         input logic v);
    mkflags = {r[DataW-1], (r == '0), c, v};
  endfunction
endpackage
`default_nettype wire

// ----- design/abeu_ctrl.sv -----
// controller state machine of the alu branch execute unit
`default_nettype none
module abeu_ctrl import abeu_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    in_fire,
  input  wire logic    out_fire,
  input  dp_sts_t      sts,
  output dp_cmd_t      cmd,
  output logic         in_ready,
  output logic         out_valid
);
  typedef enum logic [4:0] {
    S_IDLE = 5'b00001, S_MUL = 5'b00010, S_DIV = 5'b00100,
    S_FIN = 5'b01000, S_OUT = 5'b10000
  } state_t;

  state_t state_r, state_nxt;
  logic [DivCntW-1:0] cnt_r, cnt_nxt;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt = cnt_r;
    cmd = '0;
    in_ready = 1'b0;
    out_valid = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_fire) begin
          cmd.load = 1'b1;
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        // operands latched, product register loads here
        cnt_nxt = '0;
        state_nxt = sts.is_div ? S_DIV : S_FIN;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == DivCntW'(DataW - 1)) state_nxt = S_FIN;
      end
      S_FIN: begin
        cmd.finish = 1'b1;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        out_valid = 1'b1;
        in_ready = out_fire;
        if (out_fire) begin
          if (in_fire) begin
            cmd.load = 1'b1;
            state_nxt = S_MUL;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r <= cnt_nxt;
    end
  end
endmodule
`default_nettype wire

// ----- design/abeu_dpath.sv -----
// datapath of the alu branch execute unit
`default_nettype none
module abeu_dpath import abeu_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  dp_cmd_t               cmd,
  input  wire logic [OpW-1:0]   op_in,
  input  wire logic [DataW-1:0] a_in,
  input  wire logic [DataW-1:0] b_in,
  input  wire logic [CsW-1:0]   cs_hi,
  output dp_sts_t               sts,
  output res_t                  res
);
  logic [OpW-1:0] op_r;
  logic [DataW-1:0] a_r, b_r;
  logic signed [2*DataW-1:0] prod_r;
  logic [DataW-1:0] quo_r, rem_r, ua_w, ub_w;
  logic [3:0] flags_r;
  res_t res_r, res_nxt;
  logic [3:0] f, fl;
  logic [DataW:0] trial;
  logic [DataW-1:0] r_sub, q_s, m_s, sh_r;
  logic [DataW-1:0] tgt;
  logic cond;
  logic [DataW-1:0] bx;

  assign sts.is_div = (op_r == OP_DIV) && (b_r != '0);
  assign res = res_r;

  assign ua_w = a_r[DataW-1] ? (~a_r + 1'b1) : a_r;
  assign ub_w = b_r[DataW-1] ? (~b_r + 1'b1) : b_r;
  assign trial = {rem_r, quo_r[DataW-1]} - {1'b0, ub_w};

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r <= op_in;
      a_r <= a_in;
      b_r <= b_in;
    end
    // registered multiply of the latched operands
    prod_r <= $signed(a_r) * $signed(b_r);
    if (!cmd.div_step && !cmd.finish) begin
      quo_r <= ua_w;
      rem_r <= '0;
    end else if (cmd.div_step) begin
      if (!trial[DataW]) begin
        rem_r <= trial[DataW-1:0];
        quo_r <= {quo_r[DataW-2:0], 1'b1};
      end else begin
        rem_r <= {rem_r[DataW-2:0], quo_r[DataW-1]};
        quo_r <= {quo_r[DataW-2:0], 1'b0};
      end
    end
    if (cmd.finish) res_r <= res_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) flags_r <= '0;
    else if (cmd.finish) flags_r <= res_nxt.flags_now;
  end

  always_comb begin
    res_nxt = '0;
    f = flags_r;
    fl = flags_r;
    cond = 1'b0;
    tgt = {cs_hi, a_r[15:0]};
    r_sub = a_r - b_r;
    q_s = (a_r[DataW-1] != b_r[DataW-1]) ? (~quo_r + 1'b1) : quo_r;
    m_s = a_r[DataW-1] ? (~rem_r + 1'b1) : rem_r;
    bx = b_r;
    sh_r = '0;
    case (op_r)
      OP_SYS: res_nxt.status = ST_SYS;
      OP_JMP: cond = 1'b1;
      OP_JP: cond = !fl[3] && !fl[2];
      OP_JN: cond = fl[3];
      OP_JZ: cond = fl[2];
      OP_JC: cond = fl[1];
      OP_JV: cond = fl[0];
      OP_JNP: cond = fl[3] || fl[2];
      OP_JNN: cond = !fl[3];
      OP_JNZ: cond = !fl[2];
      OP_NOT: begin
        res_nxt.write_a = 1'b1; res_nxt.value_a = ~a_r; f = mkflags(~a_r, 1'b0, 1'b0);
      end
      OP_STOP: begin
        res_nxt.jump_taken = 1'b1; res_nxt.jump_target = '1;
      end
      OP_MOV: begin
        res_nxt.write_a = 1'b1; res_nxt.value_a = b_r; f = mkflags(b_r, 1'b0, 1'b0);
      end
      OP_ADD: begin
        res_nxt.write_a = 1'b1; res_nxt.value_a = a_r + b_r;
        f = mkflags(a_r + b_r, $signed(a_r + b_r) < $signed(a_r),
                    (a_r[DataW-1] == b_r[DataW-1]) &&
                    (res_nxt.value_a[DataW-1] != a_r[DataW-1]));
      end
      OP_SUB: begin
        res_nxt.write_a = 1'b1; res_nxt.value_a = r_sub;
        f = mkflags(r_sub,
                    ($signed(r_sub) < $signed(a_r)) || (b_r == {1'b1, {(DataW-1){1'b0}}}),
                    (a_r[DataW-1] != b_r[DataW-1]) && (r_sub[DataW-1] != a_r[DataW-1]));
      end
      OP_CMP: f = mkflags(r_sub, !($signed(a_r) < $signed(b_r)),
                          (a_r[DataW-1] != b_r[DataW-1]) && (r_sub[DataW-1] != a_r[DataW-1]));
      OP_MUL: begin
        res_nxt.write_a = 1'b1; res_nxt.value_a = prod_r[DataW-1:0];
        f = mkflags(prod_r[DataW-1:0],
                    !prod_r[2*DataW-1] && (prod_r[2*DataW-2:DataW] != '0),
                    prod_r[2*DataW-1:DataW-1] != {(DataW+1){prod_r[DataW-1]}});
      end
      OP_DIV: begin
        if (b_r == '0) begin
          res_nxt.status = ST_DIV0;
        end else begin
          res_nxt.write_a = 1'b1; res_nxt.value_a = q_s;
          res_nxt.remainder_valid = 1'b1; res_nxt.remainder = m_s;
          f = mkflags(q_s, 1'b0, 1'b0);
        end
      end
      OP_AND: begin
        res_nxt.write_a = 1'b1; res_nxt.value_a = a_r & b_r;
        f = mkflags(a_r & b_r, 1'b0, 1'b0);
      end
      OP_OR: begin
        res_nxt.write_a = 1'b1; res_nxt.value_a = a_r | b_r;
        f = mkflags(a_r | b_r, 1'b0, 1'b0);
      end
      OP_XOR: begin
        res_nxt.write_a = 1'b1; res_nxt.value_a = a_r ^ b_r;
        f = mkflags(a_r ^ b_r, 1'b0, 1'b0);
      end
      OP_SWAP: begin
        res_nxt.write_a = 1'b1; res_nxt.value_a = b_r;
        res_nxt.write_b = 1'b1; res_nxt.value_b = a_r;
        f = mkflags(a_r ^ b_r, 1'b0, 1'b0);
      end
      OP_SHL, OP_SHR, OP_SAR: begin
        if (bx >= 1 && bx <= DataW - 1) begin
          if (op_r == OP_SHL) begin
            sh_r = a_r << bx[4:0]; f = mkflags(sh_r, 1'b0, a_r[DataW-1]);
          end else if (op_r == OP_SHR) begin
            sh_r = a_r >> bx[4:0]; f = mkflags(sh_r, 1'b0, a_r[DataW-1]);
          end else begin
            sh_r = DataW'($signed(a_r) >>> bx[4:0]);
            f = mkflags(sh_r, a_r[bx[4:0] - 5'd1], 1'b0);
          end
          res_nxt.write_a = 1'b1; res_nxt.value_a = sh_r;
        end
      end
      OP_LDL: begin
        res_nxt.write_a = 1'b1; res_nxt.value_a = {a_r[DataW-1:16], b_r[15:0]};
      end
      OP_LDH: begin
        res_nxt.write_a = 1'b1; res_nxt.value_a = {b_r[15:0], a_r[15:0]};
      end
      default: res_nxt.status = ST_BADOP;
    endcase
    if (cond) begin
      res_nxt.jump_taken = 1'b1; res_nxt.jump_target = tgt;
    end
    res_nxt.flags_now = f;
  end
endmodule
`default_nettype wire

// ----- design/alu_branch_execute_unit_core.sv -----
// top level of the alu branch execute unit
`default_nettype none
// Execute stage of a 32-bit machine: one opcode and two operands come in per
// input beat and one result beat goes out, carrying register writes, the new
// N Z C V flags, a jump target, a division remainder and a status. The block
// works on one beat at a time: ordinary opcodes and MUL pass from acceptance to
// result through operand latch, registered product and result register; DIV
// with a nonzero divisor also runs the 32-step restoring divider before the
// result register. A new beat is taken in the same cycle the pending result is
// taken, so a beat is never accepted before the last one's result leaves. The
// flags clear at reset; cfg_wdata gives the upper half of jump targets.
module alu_branch_execute_unit_core import abeu_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_we,
  input  wire logic [CsW-1:0]     cfg_wdata,   // code_segment_high
  input  wire logic               in_tvalid,
  output logic                    in_tready,
  input  wire logic [2*DataW-1:0] in_tdata,    // val_a, val_b
  input  wire logic [OpW-1:0]     in_tuser,    // action
  output logic                    out_tvalid,
  input  wire logic               out_tready,
  // write_a, value_a, write_b, value_b, flags_now, jump_taken, jump_target,
  // remainder_valid, remainder, status, zero fill
  output logic [143:0]            out_tdata
);
  logic [CsW-1:0] cs_r;
  dp_cmd_t cmd;
  dp_sts_t sts;
  res_t res;
  logic in_fire, out_fire;

  assign in_fire = in_tvalid && in_tready;
  assign out_fire = out_tvalid && out_tready;

  // code segment register
  always_ff @(posedge clk) begin
    if (!rst_n) cs_r <= '0;
    else if (cfg_we) cs_r <= cfg_wdata;
  end

  abeu_ctrl u_ctrl (
    .clk, .rst_n, .in_fire, .out_fire, .sts, .cmd,
    .in_ready(in_tready), .out_valid(out_tvalid)
  );

  abeu_dpath u_dpath (
    .clk, .rst_n, .cmd, .op_in(in_tuser),
    .a_in(in_tdata[DataW-1:0]), .b_in(in_tdata[2*DataW-1:DataW]),
    .cs_hi(cs_r), .sts, .res
  );

  // pack result fields from the low bit up
  assign out_tdata = {6'b0, res.status, res.remainder, res.remainder_valid,
                      res.jump_target, res.jump_taken, res.flags_now,
                      res.value_b, res.write_b, res.value_a, res.write_a};
endmodule
`default_nettype wire

// ----- design/abeu_checker.sv -----
// port-level checker for the alu branch execute unit
`default_nettype none
`include "alu_branch_execute_unit_core_macros.svh"
module abeu_checker (
  input wire logic         clk,
  input wire logic         rst_n,
  input wire logic         in_tvalid,
  input wire logic         in_tready,
  input wire logic         out_tvalid,
  input wire logic         out_tready,
  input wire logic [143:0] out_tdata
);
  `ABE_ASSERT_NXT(a_in_gives_no_instant_out, clk, rst_n, in_tvalid && in_tready && !out_tvalid, !out_tvalid, "result appeared a cycle after acceptance")
  `ABE_ASSERT_NXT(a_out_holds, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata), "stalled result changed")
  `ABE_ASSERT_IMP(a_ready_only_idle, clk, rst_n, out_tvalid && !out_tready, !in_tready, "input taken while result waits")
  `ABE_ASSERT_IMP(a_status_clean, clk, rst_n, out_tvalid && out_tdata[137:136] != 2'd0, out_tdata[0] == 1'b0, "write with bad status")
endmodule
bind alu_branch_execute_unit_core abeu_checker u_abeu_checker (
  .clk, .rst_n, .in_tvalid, .in_tready, .out_tvalid, .out_tready, .out_tdata
);
`default_nettype wire

// ----- tb/tb.sv -----
// testbench for the alu branch execute unit: directed and random opcode streams
`timescale 1ns / 100ps
`default_nettype none
module tb;
  import abeu_pkg::*;

  // an opcode outside the defined set
  localparam logic [4:0] OP_BAD = 5'd31;

  // one expected result beat
  typedef struct packed {
    logic        write_a;
    logic [31:0] value_a;
    logic        write_b;
    logic [31:0] value_b;
    logic [3:0]  flags_now;
    logic        jump_taken;
    logic [31:0] jump_target;
    logic        rem_valid;
    logic [31:0] remainder;
    logic [1:0]  status;
  } exec_res_t;

  logic         clk;
  logic         rst_n;
  logic         cfg_we;
  logic [15:0]  cfg_wdata;
  logic         in_tvalid;
  wire          in_tready;
  logic [63:0]  in_tdata;
  logic [4:0]   in_tuser;
  wire          out_tvalid;
  logic         out_tready;
  wire  [143:0] out_tdata;

  // predictor state
  logic [3:0]   model_flags;
  logic [15:0]  model_cs;
  exec_res_t    pending_results[$];
  int           mismatches = 0;
  int           beats_sent = 0;
  int           beats_seen = 0;
  int           idle_cycles = 0;
  logic         rx_stall_en;

  alu_branch_execute_unit_core uut (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .in_tuser(in_tuser), .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [3:0] nzcv(input logic [31:0] r, input logic c, input logic v);
    return {r[31], r == 32'd0, c, v};
  endfunction

  function automatic logic sig_lt(input logic [31:0] a, input logic [31:0] b);
    return $signed(a) < $signed(b);
  endfunction

  // compute one expected beat and advance the predicted flags
  function automatic exec_res_t execute_op(input logic [4:0] op, input logic [31:0] a,
                                           input logic [31:0] b);
    exec_res_t   e;
    logic [31:0] r;
    logic        take;
    logic signed [63:0] prod;
    logic [31:0] ua, ub, q, m;
    logic [3:0]  f;
    e = '0;
    f = model_flags;
    take = 1'b0;
    case (op)
      OP_SYS: e.status = ST_SYS;
      OP_JMP: take = 1'b1;
      OP_JP:  take = !f[3] && !f[2];
      OP_JN:  take = f[3];
      OP_JZ:  take = f[2];
      OP_JC:  take = f[1];
      OP_JV:  take = f[0];
      OP_JNP: take = f[3] || f[2];
      OP_JNN: take = !f[3];
      OP_JNZ: take = !f[2];
      OP_NOT: begin
        r = ~a; e.write_a = 1'b1; e.value_a = r; f = nzcv(r, 1'b0, 1'b0);
      end
      OP_STOP: begin
        e.jump_taken = 1'b1; e.jump_target = '1;
      end
      OP_MOV: begin
        e.write_a = 1'b1; e.value_a = b; f = nzcv(b, 1'b0, 1'b0);
      end
      OP_ADD: begin
        r = a + b; e.write_a = 1'b1; e.value_a = r;
        f = nzcv(r, sig_lt(r, a), (a[31] == b[31]) && (r[31] != a[31]));
      end
      OP_SUB: begin
        r = a - b; e.write_a = 1'b1; e.value_a = r;
        f = nzcv(r, sig_lt(r, a) || b == 32'h8000_0000,
                 (a[31] != b[31]) && (r[31] != a[31]));
      end
      OP_CMP: begin
        r = a - b;
        f = nzcv(r, !sig_lt(a, b), (a[31] != b[31]) && (r[31] != a[31]));
      end
      OP_MUL: begin
        prod = $signed({{32{a[31]}}, a}) * $signed({{32{b[31]}}, b});
        r = prod[31:0]; e.write_a = 1'b1; e.value_a = r;
        f = nzcv(r, prod > 64'sh0_FFFF_FFFF,
                 prod < -64'sh8000_0000 || prod > 64'sh7FFF_FFFF);
      end
      OP_DIV: begin
        if (b == 32'd0) e.status = ST_DIV0;
        else begin
          ua = a[31] ? -a : a;
          ub = b[31] ? -b : b;
          q = ua / ub; m = ua % ub;
          if (a[31] != b[31]) q = -q;
          if (a[31]) m = -m;
          e.write_a = 1'b1; e.value_a = q; e.rem_valid = 1'b1; e.remainder = m;
          f = nzcv(q, 1'b0, 1'b0);
        end
      end
      OP_AND: begin r = a & b; e.write_a = 1'b1; e.value_a = r; f = nzcv(r, 1'b0, 1'b0); end
      OP_OR:  begin r = a | b; e.write_a = 1'b1; e.value_a = r; f = nzcv(r, 1'b0, 1'b0); end
      OP_XOR: begin r = a ^ b; e.write_a = 1'b1; e.value_a = r; f = nzcv(r, 1'b0, 1'b0); end
      OP_SWAP: begin
        e.write_a = 1'b1; e.value_a = b; e.write_b = 1'b1; e.value_b = a;
        f = nzcv(a ^ b, 1'b0, 1'b0);
      end
      OP_SHL, OP_SHR, OP_SAR: begin
        if (b >= 1 && b <= 31) begin
          if (op == OP_SHL) begin
            r = a << b[4:0]; f = nzcv(r, 1'b0, a[31]);
          end else if (op == OP_SHR) begin
            r = a >> b[4:0]; f = nzcv(r, 1'b0, a[31]);
          end else begin
            r = $signed(a) >>> b[4:0]; f = nzcv(r, a[b[4:0] - 5'd1], 1'b0);
          end
          e.write_a = 1'b1; e.value_a = r;
        end
      end
      OP_LDL: begin e.write_a = 1'b1; e.value_a = {a[31:16], b[15:0]}; end
      OP_LDH: begin e.write_a = 1'b1; e.value_a = {b[15:0], a[15:0]}; end
      default: e.status = ST_BADOP;
    endcase
    if (take) begin
      e.jump_taken = 1'b1; e.jump_target = {model_cs, a[15:0]};
    end
    model_flags = f;
    e.flags_now = f;
    return e;
  endfunction

  // send one beat after a random gap, record its expectation at acceptance
  task automatic send_op(input logic [4:0] op, input logic [31:0] a, input logic [31:0] b);
    int gap;
    gap = $urandom_range(0, 3) == 0 ? 0 : int'($urandom_range(0, 15));
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {b, a};
    do @(posedge clk); while (!in_tready);
    pending_results.push_back(execute_op(op, a, b));
    beats_sent++;
  endtask

  // stop sending, wait for every expected beat, then let the block settle
  task automatic drain();
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_cs(input logic [15:0] v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    model_cs = v;
  endtask

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'hFFFF_FFFF;
      3: return $urandom_range(0, 40) - 20;
      default: return $urandom;
    endcase
  endfunction

  // result check: compare each beat with the oldest expectation
  always @(posedge clk) begin
    exec_res_t e;
    exec_res_t g;
    if (rst_n && out_tvalid && out_tready) begin
      g.write_a     = out_tdata[0];
      g.value_a     = out_tdata[32:1];
      g.write_b     = out_tdata[33];
      g.value_b     = out_tdata[65:34];
      g.flags_now   = out_tdata[69:66];
      g.jump_taken  = out_tdata[70];
      g.jump_target = out_tdata[102:71];
      g.rem_valid   = out_tdata[103];
      g.remainder   = out_tdata[135:104];
      g.status      = out_tdata[137:136];
      beats_seen++;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat %h", out_tdata);
      end else begin
        e = pending_results.pop_front();
        if (g !== e) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp wa=%0b va=%h wb=%0b vb=%h f=%h jt=%0b jv=%h rv=%0b rem=%h st=%0d",
                     e.write_a, e.value_a, e.write_b, e.value_b, e.flags_now,
                     e.jump_taken, e.jump_target, e.rem_valid, e.remainder, e.status);
          if (mismatches <= 10)
            $display("          got wa=%0b va=%h wb=%0b vb=%h f=%h jt=%0b jv=%h rv=%0b rem=%h st=%0d",
                     g.write_a, g.value_a, g.write_b, g.value_b, g.flags_now,
                     g.jump_taken, g.jump_target, g.rem_valid, g.remainder, g.status);
        end
      end
    end
  end

  // receiver stalls, when enabled: a fresh draw per beat
  initial begin
    int wait_n;
    out_tready <= 1'b0;
    @(posedge rst_n);
    forever begin
      wait_n = rx_stall_en ? int'($urandom_range(0, 15)) : 0;
      if (wait_n != 0) begin
        out_tready <= 1'b0;
        repeat (wait_n) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
    end
  end

  // watchdog on cycles without any accepted beat
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 5000) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic test_jumps();
    write_cs(16'h0000);
    send_op(OP_JMP, 32'hFFFF_ABCD, 0);
    send_op(OP_CMP, 5, 5);
    for (int op = OP_JP; op <= OP_JNZ; op++) send_op(op[4:0], 32'h1234, 0);
    send_op(OP_SUB, 32'h8000_0000, 1);
    for (int op = OP_JP; op <= OP_JNZ; op++) send_op(op[4:0], 32'h5678, 0);
  endtask

  task automatic test_arith_edges();
    send_op(OP_SYS, 1, 2);
    send_op(OP_STOP, 0, 0);
    send_op(OP_DIV, 32'h8000_0000, 32'hFFFF_FFFF);
    send_op(OP_DIV, -7, 2);
    send_op(OP_DIV, 9, 0);
    send_op(OP_MUL, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_op(OP_MUL, 32'h8000_0000, 32'hFFFF_FFFF);
    send_op(OP_SHL, 32'h8000_0001, 0);
    send_op(OP_SAR, 32'h8000_0000, 31);
    send_op(OP_SHR, 32'hFFFF_FFFF, 32);
    send_op(OP_SWAP, 32'hFFFF_FFFF, 32'h0);
    send_op(OP_LDH, 32'h1234_5678, 32'hFFFF_ABCD);
    send_op(OP_BAD, 0, 0);
  endtask

  task automatic test_random(input int n);
    logic [4:0]  op;
    logic [31:0] b;
    for (int i = 0; i < n; i++) begin
      op = $urandom_range(0, 9) == 0 ? 5'($urandom_range(27, 31)) : 5'($urandom_range(0, 26));
      b = rand_word();
      if ((op == OP_SHL || op == OP_SHR || op == OP_SAR) && $urandom_range(0, 3) != 0)
        b = $urandom_range(1, 31);
      if (op == OP_DIV && $urandom_range(0, 9) == 0) b = 0;
      send_op(op, rand_word(), b);
      if (i == n / 2) drain();
    end
  endtask

  initial begin
    rst_n = 1'b0; cfg_we = 1'b0; cfg_wdata = '0; in_tvalid = 1'b0;
    in_tdata = '0; in_tuser = '0;
    model_flags = '0; model_cs = '0;
    rx_stall_en = 1'b1;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_jumps();
    test_arith_edges();
    drain();
    write_cs(16'hFFFF);
    test_random(600);
    drain();
    write_cs(16'hA5C3);
    rx_stall_en = 1'b0;
    test_random(500);
    drain();
    write_cs(16'h5A3C);
    rx_stall_en = 1'b1;
    test_random(600);
    drain();
    $display("sent %0d beats, checked %0d results", beats_sent, beats_seen);
    $display("covered all opcodes, jumps on every flag, divide and shift corners");
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule
`default_nettype wire

// ----- alu_branch_execute_unit_core.f -----
+incdir+design
design/abeu_pkg.sv
design/abeu_ctrl.sv
design/abeu_dpath.sv
design/alu_branch_execute_unit_core.sv
design/abeu_checker.sv
tb/tb.sv
